### src/assert_macros.svh
// Assertion macros shared by the grid stack field evaluator.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks a property on every rising clock edge outside of reset.
`define GSPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("grid stack assertion failed");
`endif

### src/gspf_pkg.sv
// Types, constants and the divider step shared by the grid stack field evaluator.
// Depends on nothing.
`default_nettype none
package gspf_pkg;
    localparam int ZW       = 24;  // position width
    localparam int VW       = 24;  // voltage width
    localparam int BW       = 20;  // boundary width, signed
    localparam int GW       = 16;  // gap width
    localparam int FW       = 40;  // field width
    localparam int RW       = 3;   // region width
    localparam int NW       = 41;  // dividend magnitude width
    localparam int DivSteps = NW;
    localparam int FieldScale = 10000;

    localparam logic [2:0] RegSheath    = 3'd0;
    localparam logic [2:0] RegGaps      = 3'd1;
    localparam logic [2:0] RegPlasma    = 3'd2;
    localparam logic [2:0] RegGrid0     = 3'd3;
    localparam logic [2:0] RegGrid1     = 3'd4;
    localparam logic [2:0] RegGrid2     = 3'd5;
    localparam logic [2:0] RegGrid3     = 3'd6;
    localparam logic [2:0] RegCollector = 3'd7;

    localparam logic [RW-1:0] RegionSheath  = 3'd0;
    localparam logic [RW-1:0] RegionGap0    = 3'd1;
    localparam logic [RW-1:0] RegionGap1    = 3'd2;
    localparam logic [RW-1:0] RegionGap2    = 3'd3;
    localparam logic [RW-1:0] RegionGap3    = 3'd4;
    localparam logic [RW-1:0] RegionOutside = 3'd5;

    typedef struct packed {
        logic                 vld;
        logic [RW-1:0]        region;
        logic                 wzero;
        logic signed [VW-1:0] vu;
        logic                 pneg;
        logic                 fneg;
    } side_t;

    // One restoring division step: returns the new remainder and the quotient bit.
    function automatic logic [GW:0] div_step(input logic [GW-1:0] rem, input logic nb,
                                             input logic [GW-1:0] w);
        logic [GW:0] t;
        logic        ge;
        logic [GW:0] r;
        t  = {rem, nb};
        ge = (t >= {1'b0, w});
        r  = ge ? (t - {1'b0, w}) : t;
        return {r[GW-1:0], ge};
    endfunction
endpackage
`default_nettype wire

### src/gspf_div.sv
// Pipelined restoring divider, two lanes sharing one 16-bit divisor, one bit per stage.
// Depends on gspf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module gspf_div (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       en,
    input  gspf_pkg::side_t           side_in,
    input  wire [gspf_pkg::NW-1:0]    pnum_in,
    input  wire [gspf_pkg::NW-1:0]    fnum_in,
    input  wire [gspf_pkg::GW-1:0]    w_in,
    output gspf_pkg::side_t           side_out,
    output logic [gspf_pkg::NW-1:0]   pq,
    output logic [gspf_pkg::NW-1:0]   fq
);
    import gspf_pkg::*;

    side_t          side_reg [DivSteps];
    logic [GW-1:0]  w_reg    [DivSteps];
    logic [GW-1:0]  prem_reg [DivSteps];
    logic [GW-1:0]  frem_reg [DivSteps];
    logic [NW-1:0]  pq_reg   [DivSteps];
    logic [NW-1:0]  fq_reg   [DivSteps];

    genvar i;
    generate
        for (i = 0; i < DivSteps; i++)
        begin : g_step
            side_t         s_in;
            logic [GW-1:0] w_i;
            logic [GW-1:0] pr_i;
            logic [GW-1:0] fr_i;
            logic [NW-1:0] pq_i;
            logic [NW-1:0] fq_i;
            logic [GW:0]   pstep;
            logic [GW:0]   fstep;
            if (i == 0)
            begin : g_first
                assign s_in = side_in;
                assign w_i  = w_in;
                assign pr_i = '0;
                assign fr_i = '0;
                assign pq_i = pnum_in;
                assign fq_i = fnum_in;
            end
            else
            begin : g_next
                assign s_in = side_reg[i-1];
                assign w_i  = w_reg[i-1];
                assign pr_i = prem_reg[i-1];
                assign fr_i = frem_reg[i-1];
                assign pq_i = pq_reg[i-1];
                assign fq_i = fq_reg[i-1];
            end
            // The dividend shifts out at the top while quotient bits enter at the bottom.
            assign pstep = div_step(pr_i, pq_i[NW-1], w_i);
            assign fstep = div_step(fr_i, fq_i[NW-1], w_i);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[i] <= '0;
                end
                else if (en)
                begin
                    side_reg[i] <= s_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    w_reg[i]    <= w_i;
                    prem_reg[i] <= pstep[GW:1];
                    frem_reg[i] <= fstep[GW:1];
                    pq_reg[i]   <= {pq_i[NW-2:0], pstep[0]};
                    fq_reg[i]   <= {fq_i[NW-2:0], fstep[0]};
                end
            end
        end
    endgenerate

    assign side_out = side_reg[DivSteps-1];
    assign pq       = pq_reg[DivSteps-1];
    assign fq       = fq_reg[DivSteps-1];

    // A nonzero divisor always leaves a remainder below it.
    `GSPF_ASSERT(a_rem_below_w, (side_reg[0].vld && w_reg[0] != '0) |-> (prem_reg[0] < w_reg[0]))
    // Zero width is only seen for a zero sheath or for a position outside the stack.
    `GSPF_ASSERT(a_wzero_sheath, (side_out.vld && side_out.wzero) |-> (side_out.region == RegionSheath || side_out.region == RegionOutside))
    `GSPF_ASSERT(a_region_range, side_out.vld |-> (side_out.region <= RegionOutside))
endmodule
`default_nettype wire

### src/grid_stack_potential_field_eval.sv
// Top level of the grid stack potential and field evaluator.
// Depends on gspf_pkg, gspf_div and assert_macros.svh.
//
// Usage: configuration words arrive on cfg (cfg_valid, cfg_ready, cfg_index, cfg_data);
// cfg_ready is always high and a word is taken whenever cfg_valid is high. Changes to
// sheath and gaps go via boundary registers, so write only while no position is in flight.
// Positions arrive as words on s_axis; each produces one word on m_axis holding the
// potential in mV, the field in V/m and the region code.
// Throughput is one word per cycle while the receiver does not stall the pipeline. An
// accepted word loads the first of 46 register stages: input register, region select,
// multiply, sum, 41 divider stages (one quotient bit each, set by the 41-bit dividend) and
// the output register, which drives m_axis_tvalid.
// When the receiver holds m_axis_tready low with a word waiting, the whole pipeline
// freezes and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits and the config registers; m_axis_tvalid is low after reset.
`default_nettype none
`include "assert_macros.svh"
module grid_stack_potential_field_eval (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // position[23:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata    // potential[23:0], field[63:24], region[66:64], zero
);
    import gspf_pkg::*;

    logic [GW-1:0]        sheath_reg;
    logic [63:0]          gaps_reg;
    logic signed [VW-1:0] volt_reg [6];
    logic signed [BW-1:0] bnd_reg  [6];
    logic signed [BW-1:0] bnd_next [6];

    logic en;
    assign cfg_ready     = 1'b1;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sheath_reg <= '0;
            gaps_reg   <= '0;
            for (int k = 0; k < 6; k++)
            begin
                volt_reg[k] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                RegSheath:    sheath_reg  <= cfg_data[GW-1:0];
                RegGaps:      gaps_reg    <= cfg_data;
                RegPlasma:    volt_reg[0] <= cfg_data[VW-1:0];
                RegGrid0:     volt_reg[1] <= cfg_data[VW-1:0];
                RegGrid1:     volt_reg[2] <= cfg_data[VW-1:0];
                RegGrid2:     volt_reg[3] <= cfg_data[VW-1:0];
                RegGrid3:     volt_reg[4] <= cfg_data[VW-1:0];
                RegCollector: volt_reg[5] <= cfg_data[VW-1:0];
                default:      ;
            endcase
        end
    end

    // Boundaries step down from grid zero by each gap in turn; the sheath boundary lies above it.
    always_comb
    begin
        bnd_next[0] = signed'({{(BW-GW){1'b0}}, sheath_reg});
        bnd_next[1] = '0;
        for (int k = 0; k < 4; k++)
        begin
            bnd_next[k+2] = bnd_next[k+1] - signed'({{(BW-GW){1'b0}}, gaps_reg[16*k +: GW]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                bnd_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < 6; k++)
            begin
                bnd_reg[k] <= bnd_next[k];
            end
        end
    end

    // Stage 1: input register.
    logic                 v1_reg;
    logic signed [ZW-1:0] z_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg <= s_axis_tdata;
        end
    end

    // Stage 2: region select and operand pick.
    logic signed [ZW:0]   zx;
    logic signed [ZW:0]   bx [6];
    logic [RW-1:0]        region_next;
    logic signed [BW-1:0] zu_next, zl_next;
    logic signed [VW-1:0] vu_next, vl_next;
    logic signed [ZW:0]   dz1_full, dz2_full;
    logic signed [BW:0]   w_full;

    always_comb
    begin
        zx = {z_reg[ZW-1], z_reg};
        for (int k = 0; k < 6; k++)
        begin
            bx[k] = {{(ZW+1-BW){bnd_reg[k][BW-1]}}, bnd_reg[k]};
        end
        if (zx <= bx[0] && zx >= bx[1])
            region_next = RegionSheath;
        else if (zx < bx[1] && zx >= bx[2])
            region_next = RegionGap0;
        else if (zx < bx[2] && zx >= bx[3])
            region_next = RegionGap1;
        else if (zx < bx[3] && zx >= bx[4])
            region_next = RegionGap2;
        else if (zx < bx[4] && zx >= bx[5])
            region_next = RegionGap3;
        else
            region_next = RegionOutside;

        case (region_next)
            RegionSheath: begin zu_next = bnd_reg[0]; zl_next = bnd_reg[1];
                                vu_next = volt_reg[0]; vl_next = volt_reg[1]; end
            RegionGap0:   begin zu_next = bnd_reg[1]; zl_next = bnd_reg[2];
                                vu_next = volt_reg[1]; vl_next = volt_reg[2]; end
            RegionGap1:   begin zu_next = bnd_reg[2]; zl_next = bnd_reg[3];
                                vu_next = volt_reg[2]; vl_next = volt_reg[3]; end
            RegionGap2:   begin zu_next = bnd_reg[3]; zl_next = bnd_reg[4];
                                vu_next = volt_reg[3]; vl_next = volt_reg[4]; end
            RegionGap3:   begin zu_next = bnd_reg[4]; zl_next = bnd_reg[5];
                                vu_next = volt_reg[4]; vl_next = volt_reg[5]; end
            default:      begin zu_next = '0; zl_next = '0;
                                vu_next = '0; vl_next = '0; end
        endcase
        dz1_full = zx - {{(ZW+1-BW){zl_next[BW-1]}}, zl_next};
        dz2_full = {{(ZW+1-BW){zu_next[BW-1]}}, zu_next} - zx;
        w_full   = {zu_next[BW-1], zu_next} - {zl_next[BW-1], zl_next};
    end

    logic                 v2_reg;
    logic [RW-1:0]        region2_reg;
    logic [GW:0]          dz1_reg, dz2_reg;
    logic [GW-1:0]        w2_reg;
    logic signed [VW-1:0] vu2_reg, vl2_reg;
    logic signed [VW:0]   dv2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            region2_reg <= region_next;
            dz1_reg     <= dz1_full[GW:0];
            dz2_reg     <= dz2_full[GW:0];
            w2_reg      <= w_full[GW-1:0];
            vu2_reg     <= vu_next;
            vl2_reg     <= vl_next;
            dv2_reg     <= {vl_next[VW-1], vl_next} - {vu_next[VW-1], vu_next};
        end
    end

    // Stage 3: products.
    logic                 v3_reg;
    logic [RW-1:0]        region3_reg;
    logic [GW-1:0]        w3_reg;
    logic signed [VW-1:0] vu3_reg;
    logic signed [VW+GW+1:0] p1_reg, p2_reg;
    logic signed [FW-1:0] pf_reg;
    localparam logic signed [15:0] ScaleS = 16'(FieldScale);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            region3_reg <= region2_reg;
            w3_reg      <= w2_reg;
            vu3_reg     <= vu2_reg;
            p1_reg      <= vu2_reg * signed'({1'b0, dz1_reg});
            p2_reg      <= vl2_reg * signed'({1'b0, dz2_reg});
            pf_reg      <= dv2_reg * ScaleS;
        end
    end

    // Stage 4: numerator sum and split into sign and magnitude.
    logic signed [VW+GW+2:0] psum;
    logic [VW+GW+2:0]        pmag;
    logic [FW-1:0]           fmag;
    always_comb
    begin
        psum = {p1_reg[VW+GW+1], p1_reg} + {p2_reg[VW+GW+1], p2_reg};
        pmag = psum[VW+GW+2] ? (~psum + 1'b1) : psum;
        fmag = pf_reg[FW-1] ? (~pf_reg + 1'b1) : pf_reg;
    end

    side_t         side4_reg;
    logic [NW-1:0] pnum4_reg, fnum4_reg;
    logic [GW-1:0] w4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side4_reg <= '0;
        end
        else if (en)
        begin
            side4_reg.vld    <= v3_reg;
            side4_reg.region <= region3_reg;
            side4_reg.wzero  <= (w3_reg == '0);
            side4_reg.vu     <= vu3_reg;
            side4_reg.pneg   <= psum[VW+GW+2];
            side4_reg.fneg   <= pf_reg[FW-1];
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pnum4_reg <= pmag[NW-1:0];
            fnum4_reg <= {1'b0, fmag};
            w4_reg    <= w3_reg;
        end
    end

    side_t         side_d;
    logic [NW-1:0] pq_d, fq_d;
    gspf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (side4_reg),
        .pnum_in  (pnum4_reg),
        .fnum_in  (fnum4_reg),
        .w_in     (w4_reg),
        .side_out (side_d),
        .pq       (pq_d),
        .fq       (fq_d)
    );

    // Output stage: restore signs, zero both outputs outside the stack, pass vu for zero width.
    // The field quotient stays well inside 40 bits, so truncating it to 40 bits loses nothing.
    logic [NW-1:0]        pq_s, fq_s;
    logic signed [VW-1:0] pot_next;
    logic signed [FW-1:0] fld_next;
    always_comb
    begin
        pq_s = side_d.pneg ? (~pq_d + 1'b1) : pq_d;
        fq_s = side_d.fneg ? (~fq_d + 1'b1) : fq_d;
        if (side_d.region == RegionOutside)
        begin
            pot_next = '0;
            fld_next = '0;
        end
        else if (side_d.wzero)
        begin
            pot_next = side_d.vu;
            fld_next = '0;
        end
        else
        begin
            pot_next = pq_s[VW-1:0];
            fld_next = fq_s[FW-1:0];
        end
    end

    logic                 out_vld_reg;
    logic signed [VW-1:0] pot_reg;
    logic signed [FW-1:0] fld_reg;
    logic [RW-1:0]        region_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= side_d.vld;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pot_reg    <= pot_next;
            fld_reg    <= fld_next;
            region_reg <= side_d.region;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, region_reg, fld_reg, pot_reg};

    `GSPF_ASSERT(a_ready_follows_stall, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `GSPF_ASSERT(a_outside_zero, (m_axis_tvalid && region_reg == RegionOutside) |-> (pot_reg == '0 && fld_reg == '0))
    `GSPF_ASSERT(a_frozen_on_stall, (!en) |=> $stable(side_d))
endmodule
`default_nettype wire
